// ===== sv/stepper_position_controller_assert.svh =====
// ----------------------------------------------------------------------------
// stepper position controller assertion macros
// concurrent checks sampled on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef STEPPER_POSITION_CONTROLLER_ASSERT_SVH
`define STEPPER_POSITION_CONTROLLER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SPC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// stepper position controller package
// command and mode codes, register indexes and fixed arithmetic constants
// ----------------------------------------------------------------------------
package spc_pkg;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_MOVE    = 3'd1,
    CMD_RUN     = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_SET_POS = 3'd4,
    CMD_RELEASE = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_TARGET = 2'd1,
    MODE_RUN    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_STEP_SCALE    = 2'd0,
    CFG_MIN_UM        = 2'd1,
    CFG_MAX_UM        = 2'd2,
    CFG_STEP_DELAY_MS = 2'd3
  } cfg_index_t;

  // load enables of the three conversion stages
  typedef struct packed {
    logic p;
    logic q;
    logic r;
  } conv_en_t;

  localparam int UM_WIDTH    = 21;
  localparam int SPM_WIDTH   = 12;
  localparam int DELAY_WIDTH = 16;
  localparam int NDELAY_WIDTH = 17;
  localparam int IN_DATA_WIDTH = 24;

  localparam logic [SPM_WIDTH-1:0]          SPM_RESET   = 12'd400;
  localparam logic signed [UM_WIDTH-1:0]    MIN_UM_RESET = 21'sd0;
  localparam logic signed [UM_WIDTH-1:0]    MAX_UM_RESET = 21'sd50000;
  localparam logic [DELAY_WIDTH-1:0]        DELAY_RESET = 16'd10;

  localparam logic signed [NDELAY_WIDTH-1:0] DELAY_NONE = 17'h1FFFF;

  // floor(m / 125) = (m * RECIP_125) >> RECIP_SHIFT, exact for m below 2^29
  localparam logic [29:0] RECIP_125   = 30'd549755814;
  localparam int          RECIP_SHIFT = 36;

endpackage

// ===== sv/spc_conv.sv =====
// ----------------------------------------------------------------------------
// micrometre to step conversion
// three-stage pipeline: um * step scale, divide by 1000, saturate
// ----------------------------------------------------------------------------
module spc_conv #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                             clk,
  input  spc_pkg::conv_en_t                en,
  input  logic signed [20:0]               um,
  input  logic [11:0]                      spm,
  output logic signed [POSITION_WIDTH-1:0] steps
);
  import spc_pkg::*;

  localparam logic signed [32:0] POS_HI =
    33'((64'sd1 <<< (POSITION_WIDTH - 1)) - 64'sd1);
  localparam logic signed [32:0] POS_LO = -POS_HI - 33'sd1;

  logic signed [33:0] prod;
  logic               neg;
  logic [58:0]        quo_prod;

  logic [33:0]        mag;
  logic [22:0]        quo;
  logic signed [23:0] quo_s;
  logic signed [32:0] quo_w;

  // stage p: signed product
  always_ff @(posedge clk) begin
    if (en.p) begin
      prod <= 34'(um) * 34'($signed({1'b0, spm}));
    end
  end

  // stage q: magnitude divided by 8, then reciprocal of 125
  assign mag = prod[33] ? 34'(-prod) : 34'(prod);

  always_ff @(posedge clk) begin
    if (en.q) begin
      neg      <= prod[33];
      quo_prod <= 59'(mag[31:3]) * 59'(RECIP_125);
    end
  end

  // stage r: restore sign, truncated toward zero, and clamp
  assign quo   = quo_prod[58:RECIP_SHIFT];
  assign quo_s = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign quo_w = 33'(quo_s);

  always_ff @(posedge clk) begin
    if (en.r) begin
      if (quo_w > POS_HI) begin
        steps <= POS_HI[POSITION_WIDTH-1:0];
      end else if (quo_w < POS_LO) begin
        steps <= POS_LO[POSITION_WIDTH-1:0];
      end else begin
        steps <= quo_w[POSITION_WIDTH-1:0];
      end
    end
  end

endmodule

// ===== sv/stepper_position_controller.sv =====
// ----------------------------------------------------------------------------
// stepper position controller
// step/direction position control with move, run and idle modes
// ----------------------------------------------------------------------------
// One request on the slave stream gives exactly one result on the master
// stream. A new request is taken every cycle unless a stalled output has
// filled the pipeline; a request passes the product, reciprocal and clamp
// registers, and the state update loads its result into the result register,
// and the pipeline keeps filling while a result waits at the output. The
// micrometre value goes through a multiply by step_scale, a reciprocal
// multiply for the division by 1000 and a clamp to the position range; the
// step limits run through the same conversion from min_um and max_um in two
// free-running copies. The mode, position, target and direction registers
// change in a single update when a request enters the output register, so a
// command can follow a tick directly. Configuration writes are taken every
// cycle and must only be made while no request is in flight.
module stepper_position_controller #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data,
  // requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // value_um[20:0], run_dir[21], zero pad
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  // step_pulse[0], step_direction[1], release_motor[2], next_delay_ms[19:3],
  // command_ok[20], busy_res[21], position_steps[21+POSITION_WIDTH:22], pad
  output logic [((22 + POSITION_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);
  import spc_pkg::*;

  localparam int OUT_BITS  = 22 + POSITION_WIDTH;
  localparam int OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8;

  // configuration registers
  logic [SPM_WIDTH-1:0]       step_scale;
  logic signed [UM_WIDTH-1:0] min_um;
  logic signed [UM_WIDTH-1:0] max_um;
  logic [DELAY_WIDTH-1:0]     step_delay_ms;

  // pipeline control
  logic v_p, v_q, v_r;
  logic adv_p, adv_q, adv_r, adv_out;
  logic s_accept, state_load;
  conv_en_t item_en;
  conv_en_t lim_en;

  // side fields that travel with the request
  cmd_t cmd_p, cmd_q, cmd_r;
  logic rdir_p, rdir_q, rdir_r;
  logic inr_p, inr_q, inr_r;

  logic signed [UM_WIDTH-1:0]       in_um;
  logic                             in_range;
  logic signed [POSITION_WIDTH-1:0] steps_val;
  logic signed [POSITION_WIDTH-1:0] lim_lo;
  logic signed [POSITION_WIDTH-1:0] lim_hi;

  // controller state
  mode_t                            mode, mode_next;
  logic signed [POSITION_WIDTH-1:0] position, position_next;
  logic signed [POSITION_WIDTH-1:0] target, target_next;
  logic                             direction, direction_next;

  // result fields not held in the state registers
  logic                           pulse, pulse_next;
  logic                           release_m, release_next;
  logic signed [NDELAY_WIDTH-1:0] delay, delay_next;
  logic                           ok, ok_next;
  logic                           out_valid;

  logic step_req;
  logic step_up;

  // status terms used by the result and the checks
  logic                      busy;
  logic                      delay_none;
  logic                      tick_load;
  logic                      pos_step_ok;
  logic [POSITION_WIDTH-1:0] pos_delta;

  // --------------------------------------------------------------------------
  // configuration port, always ready
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_scale    <= SPM_RESET;
      min_um        <= MIN_UM_RESET;
      max_um        <= MAX_UM_RESET;
      step_delay_ms <= DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_STEP_SCALE:    step_scale    <= cfg_data[SPM_WIDTH-1:0];
        CFG_MIN_UM:        min_um        <= $signed(cfg_data);
        CFG_MAX_UM:        max_um        <= $signed(cfg_data);
        CFG_STEP_DELAY_MS: step_delay_ms <= cfg_data[DELAY_WIDTH-1:0];
        default:           step_scale    <= step_scale;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake: each stage loads when it is empty or its successor moves on,
  // so bubbles collapse and empty stages fill while the output is stalled
  // --------------------------------------------------------------------------
  assign adv_out    = !out_valid || m_tready;
  assign adv_r      = !v_r || adv_out;
  assign adv_q      = !v_q || adv_r;
  assign adv_p      = !v_p || adv_q;
  assign s_tready   = adv_p;
  assign s_accept   = s_tvalid && s_tready;
  assign state_load = adv_out && v_r;

  assign item_en = '{p: adv_p, q: adv_q, r: adv_r};
  assign lim_en  = '{p: 1'b1, q: 1'b1, r: 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p       <= 1'b0;
      v_q       <= 1'b0;
      v_r       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_p)   v_p       <= s_accept;
      if (adv_q)   v_q       <= v_p;
      if (adv_r)   v_r       <= v_q;
      if (adv_out) out_valid <= v_r;
    end
  end

  // range check against the micrometre limits at acceptance
  assign in_um    = $signed(s_tdata[UM_WIDTH-1:0]);
  assign in_range = (in_um >= min_um) && (in_um <= max_um);

  always_ff @(posedge clk) begin
    if (adv_p) begin
      cmd_p  <= cmd_t'(s_tuser);
      rdir_p <= s_tdata[UM_WIDTH];
      inr_p  <= in_range;
    end
    if (adv_q) begin
      cmd_q  <= cmd_p;
      rdir_q <= rdir_p;
      inr_q  <= inr_p;
    end
    if (adv_r) begin
      cmd_r  <= cmd_q;
      rdir_r <= rdir_q;
      inr_r  <= inr_q;
    end
  end

  // --------------------------------------------------------------------------
  // conversions: request value and the two step limits
  // --------------------------------------------------------------------------
  spc_conv #(.POSITION_WIDTH(POSITION_WIDTH)) u_conv_value (
    .clk   (clk),
    .en    (item_en),
    .um    (in_um),
    .spm   (step_scale),
    .steps (steps_val)
  );

  // limits track the registers continuously with the same latency
  spc_conv #(.POSITION_WIDTH(POSITION_WIDTH)) u_conv_min (
    .clk   (clk),
    .en    (lim_en),
    .um    (min_um),
    .spm   (step_scale),
    .steps (lim_lo)
  );

  spc_conv #(.POSITION_WIDTH(POSITION_WIDTH)) u_conv_max (
    .clk   (clk),
    .en    (lim_en),
    .um    (max_um),
    .spm   (step_scale),
    .steps (lim_hi)
  );

  // --------------------------------------------------------------------------
  // state update for the request leaving stage r
  // --------------------------------------------------------------------------
  always_comb begin
    mode_next      = mode;
    position_next  = position;
    target_next    = target;
    direction_next = direction;
    pulse_next     = 1'b0;
    release_next   = 1'b0;
    ok_next        = 1'b1;
    delay_next     = DELAY_NONE;
    step_req       = 1'b0;
    step_up        = direction;

    case (cmd_r)
      CMD_TICK: begin
        case (mode)
          MODE_TARGET: begin
            if (target == position) begin
              mode_next = MODE_IDLE;
            end else begin
              step_up        = (target > position);
              direction_next = step_up;
              step_req       = 1'b1;
            end
          end
          MODE_RUN: begin
            step_req = 1'b1;
          end
          default: begin
            mode_next = MODE_IDLE;
          end
        endcase
      end
      CMD_MOVE: begin
        if (inr_r) begin
          target_next = steps_val;
          mode_next   = MODE_TARGET;
        end else begin
          ok_next = 1'b0;
        end
      end
      CMD_RUN: begin
        direction_next = rdir_r;
        mode_next      = MODE_RUN;
      end
      CMD_STOP: begin
        mode_next = MODE_IDLE;
      end
      CMD_SET_POS: begin
        if (inr_r) begin
          position_next = steps_val;
        end else begin
          ok_next = 1'b0;
        end
      end
      CMD_RELEASE: begin
        release_next = 1'b1;
      end
      default: begin
        // unused codes leave everything as is
        mode_next = mode;
      end
    endcase

    // one step, stopping at the limit it would pass
    if (step_req) begin
      if (step_up) begin
        if (position >= lim_hi) begin
          mode_next = MODE_IDLE;
        end else begin
          position_next = position + POSITION_WIDTH'(1);
          pulse_next    = 1'b1;
          delay_next    = $signed({1'b0, step_delay_ms});
        end
      end else begin
        if (position <= lim_lo) begin
          mode_next = MODE_IDLE;
        end else begin
          position_next = position - POSITION_WIDTH'(1);
          pulse_next    = 1'b1;
          delay_next    = $signed({1'b0, step_delay_ms});
        end
      end
    end

    // commands report the step delay while motion continues
    if ((cmd_r != CMD_TICK) && (mode_next != MODE_IDLE)) begin
      delay_next = $signed({1'b0, step_delay_ms});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      position  <= '0;
      target    <= '0;
      direction <= 1'b0;
    end else if (state_load) begin
      mode      <= mode_next;
      position  <= position_next;
      target    <= target_next;
      direction <= direction_next;
    end
  end

  // result register; state registers only move together with it
  always_ff @(posedge clk) begin
    if (state_load) begin
      pulse     <= pulse_next;
      release_m <= release_next;
      delay     <= delay_next;
      ok        <= ok_next;
    end
  end

  assign busy = (mode != MODE_IDLE);

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_WIDTH'({position, busy, ok, delay, release_m, direction, pulse});

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  assign delay_none  = (delay == DELAY_NONE);
  assign tick_load   = state_load && (cmd_r == CMD_TICK);
  assign pos_delta   = position_next - position;
  assign pos_step_ok = (pos_delta == '0) || (pos_delta == POSITION_WIDTH'(1)) || (&pos_delta);

`include "stepper_position_controller_assert.svh"

  `SPC_ASSERT_NEXT(a_accept_fills_p, s_accept, v_p, "accepted request lost at stage p")
  `SPC_ASSERT_IMPL(a_pulse_busy, out_valid && pulse, busy && !delay_none, "step without motion")
  `SPC_ASSERT_IMPL(a_idle_no_delay, out_valid && !busy, delay_none, "idle result with delay")
  `SPC_ASSERT_IMPL(a_tick_one_step, tick_load, pos_step_ok, "tick moved too far")

endmodule

// ===== test/stepper_position_controller_tb.sv =====
// ----------------------------------------------------------------------------
// stepper position controller testbench
// drives commands and register writes against an in-bench model of the axis
// and checks every result field in order of request
// ----------------------------------------------------------------------------
// Requests come from a queue that the stimulus process fills phase by phase.
// A negedge driver presents them, and a posedge monitor predicts each
// accepted request and compares each accepted result. Registers are only
// rewritten once the pipeline has drained and settled.
module stepper_position_controller_tb;
  import spc_pkg::*;

  localparam int POS_W = 24;
  localparam int RES_W = ((22 + POS_W + 7) / 8) * 8;
  // codes the block must ignore
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam longint UM_PER_MM = 1000;
  // settle time around register writes and at the end, longer than the pipeline
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [20:0] um;
    logic               dir;
  } axis_cmd_t;

  typedef struct {
    logic                    pulse;
    logic                    dir;
    logic                    rel;
    logic signed [16:0]      delay;
    logic                    ok;
    logic                    busy;
    logic signed [POS_W-1:0] pos;
  } motion_status_t;

  typedef struct {
    cfg_index_t  idx;
    logic [20:0] data;
  } reg_write_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [20:0]      cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [23:0]      s_tdata = '0;
  logic [2:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;

  stepper_position_controller #(
    .POSITION_WIDTH(POS_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus queues and handshake bookkeeping
  axis_cmd_t      pending_cmds[$];
  reg_write_t     pending_writes[$];
  motion_status_t expected_status[$];
  int             cmds_queued = 0;
  int             cmds_taken = 0;
  int             writes_queued = 0;
  int             writes_taken = 0;
  int             errors = 0;
  int             idle_pct = 20;
  logic           req_done = 1'b0;
  logic           write_done = 1'b0;
  axis_cmd_t      next_cmd;
  reg_write_t     next_write;
  axis_cmd_t      seen_cmd;
  motion_status_t got;
  motion_status_t want;

  // limits in um as last written, used to aim the random values
  int gen_min = 0;
  int gen_max = 50000;

  // ---------------------------------------------------------------------------
  // axis model: registers and state as the block should hold them
  // ---------------------------------------------------------------------------
  longint reg_spm = SPM_RESET;
  longint reg_min = MIN_UM_RESET;
  longint reg_max = MAX_UM_RESET;
  longint reg_delay = DELAY_RESET;
  mode_t  axis_mode = MODE_IDLE;
  longint axis_pos = 0;
  longint axis_target = 0;
  logic   axis_dir = 1'b0;

  // um to steps, truncating toward zero, clamped to the position range
  function automatic longint um_to_steps(longint um);
    longint s;
    longint hi;
    hi = (longint'(1) <<< (POS_W - 1)) - 1;
    s = (um * reg_spm) / UM_PER_MM;
    if (s > hi) s = hi;
    if (s < -hi - 1) s = -hi - 1;
    return s;
  endfunction

  // one step in the held direction unless the limit is already reached
  function automatic longint step_once(output logic pulse_o);
    pulse_o = 1'b0;
    if (axis_dir) begin
      if (axis_pos >= um_to_steps(reg_max)) begin
        axis_mode = MODE_IDLE;
        return -1;
      end
      axis_pos++;
    end else begin
      if (axis_pos <= um_to_steps(reg_min)) begin
        axis_mode = MODE_IDLE;
        return -1;
      end
      axis_pos--;
    end
    pulse_o = 1'b1;
    return reg_delay;
  endfunction

  function automatic motion_status_t advance_axis(axis_cmd_t c);
    motion_status_t r;
    longint um_v;
    longint delay_v;
    logic   pulse_v;
    logic   ok_v;
    logic   rel_v;
    logic   in_range;
    um_v = c.um;
    delay_v = -1;
    pulse_v = 1'b0;
    ok_v = 1'b1;
    rel_v = 1'b0;
    in_range = (um_v >= reg_min) && (um_v <= reg_max);
    if (c.cmd == CMD_TICK) begin
      if (axis_mode == MODE_TARGET) begin
        if (axis_target == axis_pos) begin
          axis_mode = MODE_IDLE;
        end else begin
          axis_dir = (axis_target > axis_pos);
          delay_v = step_once(pulse_v);
        end
      end else if (axis_mode == MODE_RUN) begin
        delay_v = step_once(pulse_v);
      end
    end else begin
      case (c.cmd)
        CMD_MOVE: begin
          if (in_range) begin
            axis_target = um_to_steps(um_v);
            axis_mode = MODE_TARGET;
          end else begin
            ok_v = 1'b0;
          end
        end
        CMD_RUN: begin
          axis_dir = c.dir;
          axis_mode = MODE_RUN;
        end
        CMD_STOP: axis_mode = MODE_IDLE;
        CMD_SET_POS: begin
          // mode is kept, so a move or run carries on from the new position
          if (in_range) axis_pos = um_to_steps(um_v);
          else ok_v = 1'b0;
        end
        CMD_RELEASE: rel_v = 1'b1;
        default: ;
      endcase
      if (axis_mode != MODE_IDLE) delay_v = reg_delay;
    end
    r.pulse = pulse_v;
    r.dir = axis_dir;
    r.rel = rel_v;
    r.delay = delay_v[16:0];
    r.ok = ok_v;
    r.busy = (axis_mode != MODE_IDLE);
    r.pos = axis_pos[POS_W-1:0];
    return r;
  endfunction

  function automatic void compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: predicts on accepted requests and writes, checks accepted results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    req_done <= s_tvalid && s_tready;
    write_done <= cfg_valid && cfg_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP_SCALE:    reg_spm = cfg_data[11:0];
          CFG_MIN_UM:        reg_min = longint'($signed(cfg_data));
          CFG_MAX_UM:        reg_max = longint'($signed(cfg_data));
          CFG_STEP_DELAY_MS: reg_delay = cfg_data[15:0];
          default: ;
        endcase
        writes_taken++;
      end
      if (s_tvalid && s_tready) begin
        seen_cmd.cmd = s_tuser;
        seen_cmd.um = s_tdata[20:0];
        seen_cmd.dir = s_tdata[21];
        expected_status.push_back(advance_axis(seen_cmd));
        cmds_taken++;
      end
      if (m_tvalid && m_tready) begin
        got.pulse = m_tdata[0];
        got.dir = m_tdata[1];
        got.rel = m_tdata[2];
        got.delay = m_tdata[19:3];
        got.ok = m_tdata[20];
        got.busy = m_tdata[21];
        got.pos = m_tdata[22 +: POS_W];
        if (expected_status.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = expected_status.pop_front();
          compare_field("step_pulse", want.pulse, got.pulse);
          compare_field("step_direction", want.dir, got.dir);
          compare_field("release_motor", want.rel, got.rel);
          compare_field("next_delay_ms", want.delay, got.delay);
          compare_field("command_ok", want.ok, got.ok);
          compare_field("busy_res", want.busy, got.busy);
          compare_field("position_steps", want.pos, got.pos);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: presents queued writes and requests, random gaps and back-pressure
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!cfg_valid || write_done) begin
        if (pending_writes.size() > 0) begin
          next_write = pending_writes.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= next_write.idx;
          cfg_data <= next_write.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
      if (!s_tvalid || req_done) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, next_cmd.dir, next_cmd.um};
          s_tuser <= next_cmd.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(logic [2:0] cmd, longint um, logic dir);
    axis_cmd_t c;
    c.cmd = cmd;
    c.um = um[20:0];
    c.dir = dir;
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  // every request answered, then a settle wait for anything still in flight
  task automatic wait_idle();
    while (cmds_taken != cmds_queued || expected_status.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(logic [11:0] spm, int lo, int hi, logic [15:0] dly);
    reg_write_t w;
    wait_idle();
    w.idx = CFG_STEP_SCALE;    w.data = {9'd0, spm};  pending_writes.push_back(w);
    w.idx = CFG_MIN_UM;        w.data = lo[20:0];     pending_writes.push_back(w);
    w.idx = CFG_MAX_UM;        w.data = hi[20:0];     pending_writes.push_back(w);
    w.idx = CFG_STEP_DELAY_MS; w.data = {5'd0, dly};  pending_writes.push_back(w);
    writes_queued += 4;
    gen_min = lo;
    gen_max = hi;
    while (writes_taken != writes_queued) @(negedge clk);
    // limit conversion runs free, give it time to follow the new registers
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly inside the limits, some exactly on them, some just past, some anywhere
  function automatic longint pick_um();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60 && gen_min <= gen_max) return gen_min + longint'($urandom_range(gen_max - gen_min));
    if (r < 70) return ($urandom_range(1)) ? gen_max : gen_min;
    if (r < 85) return ($urandom_range(1)) ? gen_max + $urandom_range(1, 3)
                                           : gen_min - $urandom_range(1, 3);
    return longint'($signed(21'($urandom())));
  endfunction

  task automatic queue_noise();
    case ($urandom_range(4))
      0: queue_cmd(CMD_STOP, $urandom(), $urandom_range(1));
      1: queue_cmd(CMD_RELEASE, $urandom(), $urandom_range(1));
      2: queue_cmd(CMD_SET_POS, pick_um(), $urandom_range(1));
      3: queue_cmd(CMD_SPARE_A, $urandom(), $urandom_range(1));
      default: queue_cmd(CMD_SPARE_B, $urandom(), $urandom_range(1));
    endcase
  endtask

  // a move, run or noise command followed by a train of ticks with occasional noise
  task automatic queue_motion_burst(int max_ticks);
    int unsigned r;
    int n;
    r = $urandom_range(99);
    if (r < 55) queue_cmd(CMD_MOVE, pick_um(), $urandom_range(1));
    else if (r < 80) queue_cmd(CMD_RUN, $urandom(), $urandom_range(1));
    else queue_noise();
    n = $urandom_range(max_ticks);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) queue_noise();
      else queue_cmd(CMD_TICK, $urandom(), $urandom_range(1));
    end
  endtask

  task automatic run_phase(int budget, int max_ticks, bit drain_midway);
    int start;
    bit drained;
    start = cmds_queued;
    drained = 1'b0;
    while (cmds_queued - start < budget) begin
      queue_motion_burst(max_ticks);
      // hold the sender back until the block has answered everything
      if (drain_midway && !drained && cmds_queued - start >= budget / 2) begin
        wait_idle();
        drained = 1'b1;
      end
      while (pending_cmds.size() > 40) @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset registers: 400 steps/mm, 0..50000 um, 10 ms
    queue_cmd(CMD_TICK, 0, 1'b0);                 // tick while idle
    queue_cmd(CMD_RELEASE, 0, 1'b0);
    queue_cmd(CMD_SPARE_A, -1, 1'b1);             // unused codes
    queue_cmd(CMD_SPARE_B, 1048575, 1'b0);
    queue_cmd(CMD_MOVE, 1, 1'b0);                 // truncates to step 0, already there
    queue_cmd(CMD_TICK, 0, 1'b0);
    queue_cmd(CMD_MOVE, -1, 1'b0);                // below min
    queue_cmd(CMD_SET_POS, 50001, 1'b0);          // above max
    queue_cmd(CMD_MOVE, -1048576, 1'b1);
    queue_cmd(CMD_SET_POS, 1048575, 1'b0);
    queue_cmd(CMD_SET_POS, 50000, 1'b0);          // at upper limit
    queue_cmd(CMD_RUN, 0, 1'b1);
    queue_cmd(CMD_TICK, 0, 1'b0);                 // upper limit stops the run
    queue_cmd(CMD_MOVE, 49990, 1'b0);
    queue_cmd(CMD_TICK, 0, 1'b0);
    queue_cmd(CMD_TICK, 0, 1'b0);
    queue_cmd(CMD_SET_POS, 0, 1'b0);              // position changes, mode kept
    queue_cmd(CMD_RUN, 0, 1'b0);
    queue_cmd(CMD_TICK, 0, 1'b0);                 // lower limit stops the run
    queue_cmd(CMD_RUN, 0, 1'b1);
    queue_cmd(CMD_TICK, 0, 1'b0);
    queue_cmd(CMD_STOP, 0, 1'b0);
    queue_cmd(CMD_TICK, 0, 1'b0);

    // zero step scale: every conversion lands on step 0
    write_regs(12'd0, -1000, 1000, 16'd3);
    queue_cmd(CMD_MOVE, 1000, 1'b0);
    queue_cmd(CMD_TICK, 0, 1'b0);

    // random phases over several register settings
    write_regs(12'd1, -10000, 12000, 16'd1);
    run_phase(300, 30, 1'b1);

    // no idling on either side through this whole phase
    write_regs(12'd4095, -5, 7, 16'd65535);
    idle_pct = 0;
    run_phase(300, 55, 1'b0);
    wait_idle();
    idle_pct = 20;

    write_regs(12'd400, -50, 60, 16'd10);
    run_phase(250, 50, 1'b0);

    // widest limits and largest scale
    write_regs(12'd4095, -1048576, 1048575, 16'd77);
    run_phase(200, 20, 1'b0);

    // min above max: no um value is accepted
    write_regs(12'd37, 300, -300, 16'd2);
    run_phase(100, 10, 1'b0);

    // single point range
    write_regs(12'd1, 0, 0, 16'd32768);
    run_phase(100, 10, 1'b0);

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/spc_pkg.sv
sv/spc_conv.sv
sv/stepper_position_controller.sv
test/stepper_position_controller_tb.sv
